// ===== hdl/utf8_to_utf16_decoder_core_defines.svh =====
// ============================================================================
// utf8_to_utf16_decoder_core_defines.svh
// Assertion macros shared by the decoder checker.
// ============================================================================
`ifndef UTF8_TO_UTF16_DECODER_CORE_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define U2U_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define U2U_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/u2u_pkg.sv =====
// ============================================================================
// u2u_pkg
// Shared types and codes for the UTF-8 to UTF-16 decoder.
// ============================================================================
`default_nettype none

package u2u_pkg;

    // unit_kind codes on the result beat
    localparam logic [1:0] KIND_UNIT     = 2'd0;
    localparam logic [1:0] KIND_END_OK   = 2'd1;
    localparam logic [1:0] KIND_END_FAIL = 2'd2;

    localparam int POINT_W = 21;

    // surrogate prefixes (top six bits of a UTF-16 unit)
    localparam logic [5:0] HI_SURR_TAG = 6'b110110;
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;

    localparam logic [POINT_W-1:0] SUPP_BASE = 21'h10000;

    typedef enum logic [1:0] {
        JOB_POINT,
        JOB_END_OK,
        JOB_END_FAIL
    } job_kind_t;

    // one queued job from front to back
    typedef struct packed {
        job_kind_t          kind;
        logic [POINT_W-1:0] point;
    } job_t;

endpackage

`default_nettype wire

// ===== hdl/utf8_to_utf16_decoder_core.sv =====
// ============================================================================
// utf8_to_utf16_decoder_core
// Streaming UTF-8 to UTF-16 decoder, one byte in, up to two units out.
// ============================================================================
// Usage:
//   Byte channel: one UTF-8 byte per beat (byte_valid/byte_stall, in_byte).
//   Unit channel: one UTF-16 code unit or end-of-string marker per beat
//   (unit_valid/unit_stall, code_unit, unit_kind, last_of_run).
//   A zero byte ends a string; its beat carries the ok/failed status.
//   A byte that finishes a unit is written to the queue at its accepting
//   edge; the output register then loads it once empty or once its beat is
//   taken. Throughput: one byte per cycle in while the queue is not full;
//   one beat per cycle out while unit_stall is low. A 4-byte sequence
//   yields two beats for four bytes, so the output keeps pace.
//   Bytes that only open or extend a sequence make no beat.
//   byte_stall rises only while the FIFO_DEPTH-entry job queue is full.
//   A stalled result holds; the front keeps taking bytes until the queue
//   fills. Reset clears the sequence state, the queue and the output valid.
// ============================================================================
`default_nettype none

module utf8_to_utf16_decoder_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  in_byte,
    output logic             unit_valid,
    input  wire logic        unit_stall,
    output logic [15:0]      code_unit,
    output logic [1:0]       unit_kind,
    output logic             last_of_run
);

    logic          byte_accept;
    logic          push;
    logic          pop;
    logic          q_empty;
    logic          q_full;
    u2u_pkg::job_t push_job;
    u2u_pkg::job_t head_job;

    // stall depends only on the registered queue fill, never on byte_valid
    assign byte_stall  = q_full;
    assign byte_accept = byte_valid && !q_full;

    // front: sequence tracking, lead byte classification
    u2u_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (byte_accept),
        .in_byte  (in_byte),
        .push     (push),
        .push_job (push_job)
    );

    // job queue decouples byte intake from result delivery
    u2u_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    // back: emits units, splits supplementary points into surrogates
    u2u_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head_job    (head_job),
        .pop         (pop),
        .unit_stall  (unit_stall),
        .unit_valid  (unit_valid),
        .code_unit   (code_unit),
        .unit_kind   (unit_kind),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

// ===== hdl/u2u_fifo.sv =====
// ============================================================================
// u2u_fifo
// Small job queue between the byte front end and the unit back end.
// ============================================================================
`default_nettype none

module u2u_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire u2u_pkg::job_t push_job,
    input  wire logic          pop,
    output u2u_pkg::job_t      head_job,
    output logic               empty,
    output logic               full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    u2u_pkg::job_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job = mem[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == FULL_CNT);

endmodule

`default_nettype wire

// ===== hdl/u2u_front.sv =====
// ============================================================================
// u2u_front
// Byte front end: tracks the open sequence and queues finished jobs.
// ============================================================================
`default_nettype none

module u2u_front (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    output logic            push,
    output u2u_pkg::job_t   push_job
);

    logic [1:0]                  due_reg, due_next;
    logic [u2u_pkg::POINT_W-1:0] pp_reg, pp_next;
    logic                        fail_reg, fail_next;
    logic [u2u_pkg::POINT_W-1:0] shifted;

    // continuation byte: low six bits appended, top bits fall off
    assign shifted = {pp_reg[u2u_pkg::POINT_W-7:0], in_byte[5:0]};

    always_comb
    begin
        due_next       = due_reg;
        pp_next        = pp_reg;
        fail_next      = fail_reg;
        push           = 1'b0;
        push_job.kind  = u2u_pkg::JOB_POINT;
        push_job.point = '0;
        if (accept)
        begin
            if (in_byte == 8'h00)
            begin
                push          = 1'b1;
                push_job.kind = (fail_reg || due_reg != 2'd0) ? u2u_pkg::JOB_END_FAIL
                                                              : u2u_pkg::JOB_END_OK;
                due_next  = 2'd0;
                pp_next   = '0;
                fail_next = 1'b0;
            end
            else if (due_reg != 2'd0)
            begin
                due_next = due_reg - 2'd1;
                pp_next  = shifted;
                if (due_reg == 2'd1)
                begin
                    push           = 1'b1;
                    push_job.point = shifted;
                    pp_next        = '0;
                end
            end
            else if (!fail_reg)
            begin
                case (in_byte) inside
                    8'b0???????:
                    begin
                        push           = 1'b1;
                        push_job.point = {13'd0, in_byte};
                    end
                    8'b110?????:
                    begin
                        pp_next  = {16'd0, in_byte[4:0]};
                        due_next = 2'd1;
                    end
                    8'b1110????:
                    begin
                        pp_next  = {17'd0, in_byte[3:0]};
                        due_next = 2'd2;
                    end
                    8'b11110???:
                    begin
                        pp_next  = {18'd0, in_byte[2:0]};
                        due_next = 2'd3;
                    end
                    default:
                    begin
                        fail_next = 1'b1;
                        pp_next   = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_reg  <= 2'd0;
            pp_reg   <= '0;
            fail_reg <= 1'b0;
        end
        else
        begin
            due_reg  <= due_next;
            pp_reg   <= pp_next;
            fail_reg <= fail_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/u2u_back.sv =====
// ============================================================================
// u2u_back
// Unit back end: turns queued jobs into result beats, splitting surrogates.
// ============================================================================
`default_nettype none

module u2u_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire u2u_pkg::job_t head_job,
    output logic               pop,
    input  wire logic          unit_stall,
    output logic               unit_valid,
    output logic [15:0]        code_unit,
    output logic [1:0]         unit_kind,
    output logic               last_of_run
);

    logic                        valid_reg, valid_next;
    logic                        half_reg, half_next;
    logic [15:0]                 cu_reg, cu_next;
    logic [1:0]                  kind_reg, kind_next;
    logic                        last_reg, last_next;
    logic                        load;
    logic                        big;
    logic [u2u_pkg::POINT_W-1:0] offs;

    assign big  = |head_job.point[u2u_pkg::POINT_W-1:16];
    assign offs = head_job.point - u2u_pkg::SUPP_BASE;
    assign load = !valid_reg || !unit_stall;

    always_comb
    begin
        valid_next = valid_reg;
        half_next  = half_reg;
        cu_next    = cu_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !q_empty;
            if (!q_empty)
            begin
                case (head_job.kind)
                    u2u_pkg::JOB_POINT:
                    begin
                        kind_next = u2u_pkg::KIND_UNIT;
                        if (big && !half_reg)
                        begin
                            cu_next   = {u2u_pkg::HI_SURR_TAG, offs[19:10]};
                            last_next = 1'b0;
                            half_next = 1'b1;
                        end
                        else if (big)
                        begin
                            cu_next   = {u2u_pkg::LO_SURR_TAG, offs[9:0]};
                            last_next = 1'b1;
                            half_next = 1'b0;
                            pop       = 1'b1;
                        end
                        else
                        begin
                            cu_next   = head_job.point[15:0];
                            last_next = 1'b1;
                            pop       = 1'b1;
                        end
                    end
                    u2u_pkg::JOB_END_OK:
                    begin
                        cu_next   = 16'd0;
                        kind_next = u2u_pkg::KIND_END_OK;
                        last_next = 1'b1;
                        pop       = 1'b1;
                    end
                    default:
                    begin
                        cu_next   = 16'd0;
                        kind_next = u2u_pkg::KIND_END_FAIL;
                        last_next = 1'b1;
                        pop       = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cu_reg   <= cu_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign unit_valid  = valid_reg;
    assign code_unit   = cu_reg;
    assign unit_kind   = kind_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

// ===== hdl/u2u_checker.sv =====
// ============================================================================
// u2u_checker
// Port-level checks on the decoder result stream.
// ============================================================================
`default_nettype none

`include "utf8_to_utf16_decoder_core_defines.svh"

module u2u_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        unit_valid,
    input wire logic        unit_stall,
    input wire logic [15:0] code_unit,
    input wire logic [1:0]  unit_kind,
    input wire logic        last_of_run
);

    `U2U_ASSERT_NEXT(a_hold, clk, rst_n, unit_valid && unit_stall, unit_valid && $stable(code_unit) && $stable(unit_kind) && $stable(last_of_run), "stalled beat changed")

    `U2U_ASSERT_NOW(a_end_beat, clk, rst_n, unit_valid && unit_kind != u2u_pkg::KIND_UNIT, code_unit == 16'd0 && last_of_run && (unit_kind == u2u_pkg::KIND_END_OK || unit_kind == u2u_pkg::KIND_END_FAIL), "bad end beat")

    `U2U_ASSERT_NOW(a_hi_surr, clk, rst_n, unit_valid && !last_of_run, unit_kind == u2u_pkg::KIND_UNIT && code_unit[15:10] == u2u_pkg::HI_SURR_TAG, "non-final beat not high surrogate")

    `U2U_ASSERT_NEXT(a_lo_follow, clk, rst_n, unit_valid && !unit_stall && !last_of_run, unit_valid && last_of_run && code_unit[15:10] == u2u_pkg::LO_SURR_TAG, "low surrogate missing")

endmodule

bind utf8_to_utf16_decoder_core u2u_checker u_u2u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .unit_valid  (unit_valid),
    .unit_stall  (unit_stall),
    .code_unit   (code_unit),
    .unit_kind   (unit_kind),
    .last_of_run (last_of_run)
);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Checks the UTF-8 to UTF-16 decoder core against its own behavioral decoder.
// A short table of hand-picked bytes (ASCII, each sequence length, surrogate
// pairs, overlong and out-of-range forms, bad leads, dropped bytes after a
// failure, strings cut short by a zero) is fed first. Random strings follow,
// most of them well formed, the rest noise and broken sequences. Both sides
// idle and stall at random over four phases.
// ============================================================================

module testbench;

    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_BYTES  = 375;
    localparam int DRAIN_CYCLES = 20;

    // Directed table row: byte, fixed-result flag, fixed kind, fixed unit.
    localparam bit FIXED     = 1'b1;
    localparam bit PREDICTED = 1'b0;
    localparam int N_DIRECTED = 28;

    localparam logic [1:0] K_UNIT = u2u_pkg::KIND_UNIT;
    localparam logic [1:0] K_OK   = u2u_pkg::KIND_END_OK;
    localparam logic [1:0] K_FAIL = u2u_pkg::KIND_END_FAIL;

    typedef struct packed {
        logic [7:0]  b;
        logic        fixed;
        logic [1:0]  kind;
        logic [15:0] unit;
    } text_row_t;

    typedef struct packed {
        logic [15:0] unit;
        logic [1:0]  kind;
        logic        last;
    } unit_beat_t;

    localparam logic [26:0] TEXT_TABLE [0:N_DIRECTED-1] = '{
        {8'h00, FIXED,     K_OK,   16'h0000},  // empty string after reset
        {8'h7F, FIXED,     K_UNIT, 16'h007F},  // top of ASCII
        {8'hC3, PREDICTED, K_UNIT, 16'h0000},  // 2-byte, continuation
        {8'h29, PREDICTED, K_UNIT, 16'h0000},  //   top bits not 10: unchecked
        {8'hE2, PREDICTED, K_UNIT, 16'h0000},  // euro sign, 3 bytes
        {8'h82, PREDICTED, K_UNIT, 16'h0000},
        {8'hAC, PREDICTED, K_UNIT, 16'h0000},
        {8'hF0, PREDICTED, K_UNIT, 16'h0000},  // 4 bytes, surrogate pair
        {8'h9F, PREDICTED, K_UNIT, 16'h0000},
        {8'h98, PREDICTED, K_UNIT, 16'h0000},
        {8'h80, PREDICTED, K_UNIT, 16'h0000},
        {8'hF7, PREDICTED, K_UNIT, 16'h0000},  // past 0x10FFFF: offset wraps
        {8'hBF, PREDICTED, K_UNIT, 16'h0000},
        {8'hBF, PREDICTED, K_UNIT, 16'h0000},
        {8'hBF, PREDICTED, K_UNIT, 16'h0000},
        {8'hF0, PREDICTED, K_UNIT, 16'h0000},  // overlong 4-byte, one unit
        {8'h80, PREDICTED, K_UNIT, 16'h0000},
        {8'h80, PREDICTED, K_UNIT, 16'h0000},
        {8'hC1, PREDICTED, K_UNIT, 16'h0000},
        {8'h00, FIXED,     K_OK,   16'h0000},
        {8'hF8, PREDICTED, K_UNIT, 16'h0000},  // bad lead 11111xxx
        {8'h41, PREDICTED, K_UNIT, 16'h0000},  //   dropped
        {8'h00, FIXED,     K_FAIL, 16'h0000},
        {8'h80, PREDICTED, K_UNIT, 16'h0000},  // bad lead 10xxxxxx
        {8'hFF, PREDICTED, K_UNIT, 16'h0000},  //   dropped
        {8'h00, FIXED,     K_FAIL, 16'h0000},
        {8'hE2, PREDICTED, K_UNIT, 16'h0000},  // zero cuts the sequence
        {8'h00, FIXED,     K_FAIL, 16'h0000}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  in_byte;
    logic        unit_valid;
    logic        unit_stall;
    logic [15:0] code_unit;
    logic [1:0]  unit_kind;
    logic        last_of_run;

    // decoder state of the predictor
    logic [1:0]  seq_left;
    logic [20:0] seq_point;
    logic        str_bad;

    unit_beat_t  units_due[$];   // expected beats, oldest first
    logic [7:0]  text[$];        // random bytes waiting to be sent
    unit_beat_t  head;
    int          errors = 0;
    int          cycles = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;

    utf8_to_utf16_decoder_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .in_byte     (in_byte),
        .unit_valid  (unit_valid),
        .unit_stall  (unit_stall),
        .code_unit   (code_unit),
        .unit_kind   (unit_kind),
        .last_of_run (last_of_run)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: timeout, %0d beats still due", $time, units_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Decode one byte; returns the number of beats it makes (0 to 2).
    function automatic int decode_byte(input logic [7:0] b,
                                       output unit_beat_t r0, output unit_beat_t r1);
        logic [20:0] pt;
        logic [20:0] off;
        int          n;
        n  = 0;
        r0 = '0;
        r1 = '0;
        if (b == 8'h00)
        begin
            r0.kind = (str_bad || seq_left != 2'd0) ? K_FAIL : K_OK;
            r0.last = 1'b1;
            seq_left  = 2'd0;
            seq_point = '0;
            str_bad   = 1'b0;
            n = 1;
        end
        else if (seq_left != 2'd0)
        begin
            seq_point = {seq_point[14:0], b[5:0]};
            seq_left  = seq_left - 2'd1;
            if (seq_left == 2'd0)
            begin
                pt = seq_point;
                seq_point = '0;
                if (pt <= 21'h00FFFF)
                begin
                    r0.unit = pt[15:0];
                    r0.kind = K_UNIT;
                    r0.last = 1'b1;
                    n = 1;
                end
                else
                begin
                    off = pt - 21'h010000;   // wraps to 20 bits past 0x10FFFF
                    r0.unit = {u2u_pkg::HI_SURR_TAG, off[19:10]};
                    r0.kind = K_UNIT;
                    r0.last = 1'b0;
                    r1.unit = {u2u_pkg::LO_SURR_TAG, off[9:0]};
                    r1.kind = K_UNIT;
                    r1.last = 1'b1;
                    n = 2;
                end
            end
        end
        else if (!str_bad)
        begin
            casez (b)
                8'b0???????:
                begin
                    r0.unit = {8'h00, b};
                    r0.kind = K_UNIT;
                    r0.last = 1'b1;
                    n = 1;
                end
                8'b110?????:
                begin
                    seq_point = {16'h0, b[4:0]};
                    seq_left  = 2'd1;
                end
                8'b1110????:
                begin
                    seq_point = {17'h0, b[3:0]};
                    seq_left  = 2'd2;
                end
                8'b11110???:
                begin
                    seq_point = {18'h0, b[2:0]};
                    seq_left  = 2'd3;
                end
                default:
                begin
                    str_bad   = 1'b1;
                    seq_point = '0;
                end
            endcase
        end
        return n;
    endfunction

    // Mostly a proper continuation byte, sometimes any nonzero byte.
    function automatic logic [7:0] tail_byte();
        if ($urandom_range(99) < 90)
            return 8'h80 | 8'($urandom_range(63));
        return 8'($urandom_range(1, 255));
    endfunction

    // Append one byte to the random text.
    task automatic add_text(input logic [7:0] b);
        text = {text, b};
    endtask

    // Queue one random string; most are well formed and end in a zero.
    task automatic build_string();
        int sel;
        if ($urandom_range(99) < 15)
        begin
            // raw noise, zeros land wherever they land
            repeat ($urandom_range(1, 12))
                add_text(8'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(1, 10))
        begin
            sel = $urandom_range(99);
            if (sel < 30)
                add_text(8'($urandom_range(1, 127)));
            else if (sel < 50)
            begin
                add_text(8'hC0 | 8'($urandom_range(31)));
                add_text(tail_byte());
            end
            else if (sel < 70)
            begin
                add_text(8'hE0 | 8'($urandom_range(15)));
                repeat (2) add_text(tail_byte());
            end
            else if (sel < 92)
            begin
                add_text(8'hF0 | 8'($urandom_range(7)));
                repeat (3) add_text(tail_byte());
            end
            else if (sel < 96)
            begin
                // bad lead; rest of the string gets dropped
                if ($urandom_range(1) == 0)
                    add_text(8'h80 | 8'($urandom_range(63)));
                else
                    add_text(8'hF8 | 8'($urandom_range(7)));
            end
            else
            begin
                // sequence cut short by a zero
                add_text(8'hF0 | 8'($urandom_range(7)));
                repeat ($urandom_range(0, 2)) add_text(tail_byte());
                add_text(8'h00);
            end
        end
        add_text(8'h00);
    endtask

    // Drive one byte beat from a falling edge, wait for it to be taken,
    // record what it should produce, and return at the next falling edge.
    task automatic send_byte(input logic [7:0] b, input logic fixed,
                             input logic [1:0] fkind, input logic [15:0] funit);
        unit_beat_t r0;
        unit_beat_t r1;
        unit_beat_t pinned;
        int         n;
        while ($urandom_range(99) < gap_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        in_byte    <= b;
        do
            @(posedge clk);
        while (byte_stall);
        n = decode_byte(b, r0, r1);
        if (fixed)
        begin
            pinned.unit = funit;
            pinned.kind = fkind;
            pinned.last = 1'b1;
            units_due = {units_due, pinned};
        end
        else
        begin
            if (n > 0)
                units_due = {units_due, r0};
            if (n > 1)
                units_due = {units_due, r1};
        end
        @(negedge clk);
    endtask

    // Receiver back-pressure, changed only at the falling edge.
    always @(negedge clk)
        unit_stall <= ($urandom_range(99) < stall_pct);

    // Result beats: compare each against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && unit_valid && !unit_stall)
        begin
            if (units_due.size() == 0)
            begin
                $display("%0t: unexpected beat unit=%h kind=%0d last=%0b",
                         $time, code_unit, unit_kind, last_of_run);
                errors++;
            end
            else
            begin
                head = units_due.pop_front();
                if (code_unit !== head.unit)
                begin
                    $display("%0t: code_unit expected %h got %h", $time, head.unit, code_unit);
                    errors++;
                end
                if (unit_kind !== head.kind)
                begin
                    $display("%0t: unit_kind expected %0d got %0d", $time, head.kind, unit_kind);
                    errors++;
                end
                if (last_of_run !== head.last)
                begin
                    $display("%0t: last_of_run expected %0b got %0b",
                             $time, head.last, last_of_run);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        text_row_t row;
        int        sent;
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        in_byte    = 8'h00;
        unit_stall = 1'b0;
        seq_left   = 2'd0;
        seq_point  = '0;
        str_bad    = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = TEXT_TABLE[i];
            send_byte(row.b, row.fixed, row.kind, row.unit);
        end

        // phases: no idling, sender gaps, receiver stalls, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 75;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 75;
                end
                default:
                begin
                    gap_pct   = 17;
                    stall_pct = 17;
                end
            endcase
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                if (text.size() == 0)
                    build_string();
                send_byte(text.pop_front(), PREDICTED, K_UNIT, 16'h0000);
                sent++;
            end
        end
        byte_valid <= 1'b0;

        while (units_due.size() != 0)
            @(posedge clk);
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/u2u_pkg.sv
hdl/u2u_fifo.sv
hdl/u2u_front.sv
hdl/u2u_back.sv
hdl/utf8_to_utf16_decoder_core.sv
hdl/u2u_checker.sv
test/testbench.sv
